/* hdl/nirp_pkg.sv */
`default_nettype none

package nirp_pkg;

    // Fixed field widths
    localparam int NIRP_DUR_W    = 20;
    localparam int NIRP_UNIT_W   = 12;
    localparam int NIRP_THR_W    = 8;
    localparam int NIRP_CODE_W   = 32;
    localparam int NIRP_CFG_W    = 12;

    // Data bits in one frame
    localparam int NIRP_FRAME_BITS = 32;

    // Default depth of the queue between front and back
    localparam int NIRP_QDEPTH = 2;

    // Timing class of one edge, computed up front
    typedef struct packed {
        logic pulse;      // carrier level
        logic hdr_pulse;  // 16u +- 2u
        logic hdr_data;   // 8u +- u
        logic hdr_rpt;    // 4u +- half
        logic unit_ok;    // u +- half
        logic three_ok;   // 3u +- half
        logic trl_ok;     // above 10u - half
    } nirp_cls_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } nirp_qstat_t;

endpackage

`default_nettype wire

/* hdl/nec_ir_pulse_decoder_top.sv */
`default_nettype none

// NEC infrared remote decoder. Each request on the slave side is one IR
// edge: s_tuser is the level (1 carrier pulse, 0 space) and s_tdata[19:0]
// its length in ticks. Every request gives exactly one request on the
// master side: m_tdata is the decoded key code and m_tuser is set when this
// edge closed a frame (trailer space of a data frame, or of a repeat frame
// once the repeat count has reached repeat_threshold); otherwise m_tdata is
// zero and m_tuser is low. Codes: raw 32 bits when the command check fails,
// addr:raddr:cmd for extended addresses, addr:cmd for plain frames, each byte
// bit-reversed as received LSB first. Edges with the wrong level or outside
// their window leave the frame state alone (a bad header space drops back to
// idle, a bad bit space still shifts in a zero). Rate: one edge per clock
// while results are taken; each edge is queued and then stepped through
// the frame state machine into the output register. The front end compares
// the duration against all timing windows at once and writes a small class
// word into a QUEUE_DEPTH entry queue; the back end pops one class word per
// cycle while the output register is free or being drained. Write unit_time
// (index 0) and repeat_threshold (index 1) only while no edge is in flight.

module nec_ir_pulse_decoder_top
    import nirp_pkg::*;
#(
    parameter int QUEUE_DEPTH = NIRP_QDEPTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [23:0]             s_tdata,   // [19:0] duration, [23:20] zero
    input  wire logic                    s_tuser,   // [0] level
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [NIRP_CODE_W-1:0]       m_tdata,   // [31:0] code
    output logic                         m_tuser,   // [0] code_valid
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [NIRP_CFG_W-1:0]   cfg_data
);

    localparam logic CFG_UNIT_TIME = 1'b0;
    localparam logic CFG_REP_THR   = 1'b1;

    logic [NIRP_UNIT_W-1:0] unit_time_reg;
    logic [NIRP_UNIT_W-1:0] unit_time_next;
    logic [NIRP_THR_W-1:0]  rep_thr_reg;
    logic [NIRP_THR_W-1:0]  rep_thr_next;

    nirp_cls_t   cls_in;
    nirp_cls_t   cls_out;
    nirp_qstat_t q_stat;
    logic        q_push;
    logic        q_pop;

    // Configuration registers
    always_comb
    begin
        unit_time_next = unit_time_reg;
        rep_thr_next   = rep_thr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT_TIME: unit_time_next = cfg_data[NIRP_UNIT_W-1:0];
                CFG_REP_THR:   rep_thr_next   = cfg_data[NIRP_THR_W-1:0];
                default:       unit_time_next = unit_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_time_reg <= NIRP_UNIT_W'(560);
            rep_thr_reg   <= NIRP_THR_W'(5);
        end
        else
        begin
            unit_time_reg <= unit_time_next;
            rep_thr_reg   <= rep_thr_next;
        end
    end

    // Front end: edge classification
    nirp_front u_front
    (
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .unit_time (unit_time_reg),
        .q_stat    (q_stat),
        .push      (q_push),
        .cls       (cls_in)
    );

    // Decoupling queue
    nirp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (cls_in),
        .pop     (q_pop),
        .rd_data (cls_out),
        .q_stat  (q_stat)
    );

    // Back end: frame state machine and output register
    nirp_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cls              (cls_out),
        .q_stat           (q_stat),
        .pop              (q_pop),
        .repeat_threshold (rep_thr_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

`ifndef SYNTH
    // No code without a completed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero code without code_valid");

    // Queue never written while full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue overflow");

    // Queue never read while empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue underflow");

    // A popped edge always yields an output request next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_tvalid)
        else $error("edge dropped between queue and output");
`endif

endmodule

`default_nettype wire

/* hdl/nirp_front.sv */
`default_nettype none

module nirp_front
    import nirp_pkg::*;
(
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [23:0]             s_tdata,
    input  wire logic                    s_tuser,
    input  wire logic [NIRP_UNIT_W-1:0]  unit_time,
    input  wire nirp_qstat_t             q_stat,
    output logic                         push,
    output nirp_cls_t                    cls
);

    localparam int CW = NIRP_DUR_W + 1;

    logic [CW-1:0] d;
    logic [CW-1:0] u1;
    logic [CW-1:0] half;
    logic [CW-1:0] u2;
    logic [CW-1:0] u3;
    logic [CW-1:0] u4;
    logic [CW-1:0] u8;
    logic [CW-1:0] u10;
    logic [CW-1:0] u16;

    // Open window (c - m, c + m)
    function automatic logic win(input logic [CW-1:0] dv,
                                 input logic [CW-1:0] c,
                                 input logic [CW-1:0] m);
        return ((dv + m) > c) && (dv < (c + m));
    endfunction

    assign d    = CW'(s_tdata[NIRP_DUR_W-1:0]);
    assign u1   = CW'(unit_time);
    assign half = u1 >> 1;
    assign u2   = u1 << 1;
    assign u4   = u1 << 2;
    assign u8   = u1 << 3;
    assign u16  = u1 << 4;
    assign u3   = u1 + u2;
    assign u10  = u8 + u2;

    always_comb
    begin
        cls.pulse     = s_tuser;
        cls.hdr_pulse = win(d, u16, u2);
        cls.hdr_data  = win(d, u8, u1);
        cls.hdr_rpt   = win(d, u4, half);
        cls.unit_ok   = win(d, u1, half);
        cls.three_ok  = win(d, u3, half);
        cls.trl_ok    = (d + half) > u10;
    end

    assign s_tready = !q_stat.full && rst_n;
    assign push     = s_tvalid && s_tready;

endmodule

`default_nettype wire

/* hdl/nirp_fifo.sv */
`default_nettype none

module nirp_fifo
    import nirp_pkg::*;
#(
    parameter int DEPTH = NIRP_QDEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire nirp_cls_t  wr_data,
    input  wire logic       pop,
    output nirp_cls_t       rd_data,
    output nirp_qstat_t     q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    nirp_cls_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [NW-1:0]   cnt_reg;
    logic [NW-1:0]   cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign rd_data      = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == NW'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

/* hdl/nirp_back.sv */
`default_nettype none

module nirp_back
    import nirp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire nirp_cls_t               cls,
    input  wire nirp_qstat_t             q_stat,
    output logic                         pop,
    input  wire logic [NIRP_THR_W-1:0]   repeat_threshold,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [NIRP_CODE_W-1:0]       m_tdata,
    output logic                         m_tuser
);

    localparam int BCW = $clog2(NIRP_FRAME_BITS) + 1;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_HDR_SPACE = 3'd1;
    localparam logic [2:0] PH_BIT_PULSE = 3'd2;
    localparam logic [2:0] PH_BIT_SPACE = 3'd3;
    localparam logic [2:0] PH_TRL_PULSE = 3'd4;
    localparam logic [2:0] PH_TRL_SPACE = 3'd5;

    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [BCW-1:0]         bc_reg;
    logic [BCW-1:0]         bc_next;
    logic [BCW-1:0]         bc_inc;
    logic [31:0]            shift_reg;
    logic [31:0]            shift_next;
    logic [7:0]             rc_reg;
    logic [7:0]             rc_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [NIRP_CODE_W-1:0] out_code_reg;
    logic [NIRP_CODE_W-1:0] out_code_next;
    logic                   out_flag_reg;
    logic                   out_flag_next;
    logic [NIRP_CODE_W-1:0] fmt_code;
    logic [7:0]             addr;
    logic [7:0]             raddr;
    logic [7:0]             cmd;
    logic [7:0]             rcmd;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

    assign addr  = rev8(shift_reg[31:24]);
    assign raddr = rev8(shift_reg[23:16]);
    assign cmd   = rev8(shift_reg[15:8]);
    assign rcmd  = rev8(shift_reg[7:0]);

    always_comb
    begin
        priority if ((cmd ^ rcmd) != 8'hff)
        begin
            fmt_code = shift_reg;
        end
        else if ((addr ^ raddr) != 8'hff)
        begin
            fmt_code = {8'h00, addr, raddr, cmd};
        end
        else
        begin
            fmt_code = {16'h0000, addr, cmd};
        end
    end

    // one edge per cycle whenever the output slot is free or drains now
    assign pop    = !q_stat.empty && (!out_valid_reg || m_tready);
    assign bc_inc = bc_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        bc_next        = bc_reg;
        shift_next     = shift_reg;
        rc_next        = rc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_code_next  = out_code_reg;
        out_flag_next  = out_flag_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_code_next  = '0;
            out_flag_next  = 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (cls.pulse && cls.hdr_pulse)
                    begin
                        bc_next    = '0;
                        phase_next = PH_HDR_SPACE;
                    end
                end
                PH_HDR_SPACE:
                begin
                    if (!cls.pulse)
                    begin
                        priority if (cls.hdr_data)
                        begin
                            rc_next    = '0;
                            phase_next = PH_BIT_PULSE;
                        end
                        else if (cls.hdr_rpt)
                        begin
                            if (rc_reg != 8'hff)
                            begin
                                rc_next = rc_reg + 1'b1;
                            end
                            phase_next = PH_TRL_PULSE;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_BIT_PULSE:
                begin
                    if (cls.pulse && cls.unit_ok)
                    begin
                        phase_next = PH_BIT_SPACE;
                    end
                end
                PH_BIT_SPACE:
                begin
                    if (!cls.pulse)
                    begin
                        // a bad space still shifts in a zero
                        shift_next = {shift_reg[30:0], cls.three_ok};
                        if (cls.three_ok || cls.unit_ok)
                        begin
                            bc_next    = bc_inc;
                            phase_next = (bc_inc == BCW'(NIRP_FRAME_BITS)) ?
                                         PH_TRL_PULSE : PH_BIT_PULSE;
                        end
                    end
                end
                PH_TRL_PULSE:
                begin
                    if (cls.pulse && cls.unit_ok)
                    begin
                        phase_next = PH_TRL_SPACE;
                    end
                end
                PH_TRL_SPACE:
                begin
                    if (!cls.pulse && cls.trl_ok)
                    begin
                        if (rc_reg == '0 || rc_reg >= repeat_threshold)
                        begin
                            out_code_next = fmt_code;
                            out_flag_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bc_reg        <= '0;
            shift_reg     <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bc_reg        <= bc_next;
            shift_reg     <= shift_next;
            rc_reg        <= rc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = out_flag_reg;

endmodule

`default_nettype wire

/* test/nec_ir_pulse_decoder_top_tb.sv */
import nirp_pkg::*;

// register indexes on the config port
localparam logic REG_UNIT_TIME  = 1'b0;
localparam logic REG_REPEAT_THR = 1'b1;

// frame walker phases
typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_SPACE,
    ST_BIT_PULSE,
    ST_BIT_SPACE,
    ST_TRL_PULSE,
    ST_TRL_SPACE
} ir_phase_t;

typedef struct packed {
    logic [NIRP_CODE_W-1:0] code;
    logic                   valid;
} ir_result_t;

// Tracks the NEC frame walk per accepted edge and holds the codes still owed.
class ir_code_scoreboard;
    ir_result_t            want_q[$];
    logic [NIRP_UNIT_W-1:0] unit_time;
    logic [NIRP_THR_W-1:0]  rpt_thresh;
    ir_phase_t             phase;
    logic [5:0]            bit_cnt;
    logic [31:0]           shift_reg;
    logic [7:0]            rpt_cnt;
    int edges = 0;
    int results = 0;
    int codes = 0;
    int repeat_codes = 0;
    int reg_writes = 0;
    int mismatches = 0;

    function new();
        unit_time  = 12'd560;
        rpt_thresh = 8'd5;
        phase      = ST_IDLE;
        bit_cnt    = '0;
        shift_reg  = '0;
        rpt_cnt    = '0;
    endfunction

    function void set_reg(logic idx, logic [NIRP_CFG_W-1:0] val);
        if (idx == REG_UNIT_TIME)
            unit_time = val;
        else
            rpt_thresh = val[NIRP_THR_W-1:0];
        reg_writes++;
    endfunction

    // open window: c - m < d < c + m
    function bit in_window(logic [31:0] d, logic [31:0] c, logic [31:0] m);
        return (d + m > c) && (d < c + m);
    endfunction

    function logic [7:0] mirror_byte(logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7-i] = b[i];
        return r;
    endfunction

    function void note_edge(logic lvl, logic [NIRP_DUR_W-1:0] dur);
        logic [31:0] u, h, d;
        logic [7:0]  addr, raddr, cmd, rcmd;
        ir_result_t  res;
        u   = {20'd0, unit_time};
        h   = u >> 1;
        d   = {12'd0, dur};
        res = '0;
        edges++;
        case (phase)
            ST_IDLE:
                if (lvl && in_window(d, u * 16, u * 2))
                begin
                    bit_cnt = '0;
                    phase   = ST_HDR_SPACE;
                end
            ST_HDR_SPACE:
                if (!lvl)
                begin
                    if (in_window(d, u * 8, u))
                    begin
                        rpt_cnt = '0;
                        phase   = ST_BIT_PULSE;
                    end
                    else if (in_window(d, u * 4, h))
                    begin
                        if (rpt_cnt != 8'hff)
                            rpt_cnt = rpt_cnt + 8'd1;
                        phase = ST_TRL_PULSE;
                    end
                    else
                        phase = ST_IDLE;
                end
            ST_BIT_PULSE:
                if (lvl && in_window(d, u, h))
                    phase = ST_BIT_SPACE;
            ST_BIT_SPACE:
                if (!lvl)
                begin
                    // a space outside both windows still shifts a zero in
                    shift_reg = shift_reg << 1;
                    if (in_window(d, u * 3, h))
                        shift_reg[0] = 1'b1;
                    if (in_window(d, u * 3, h) || in_window(d, u, h))
                    begin
                        bit_cnt = bit_cnt + 6'd1;
                        phase   = (bit_cnt == NIRP_FRAME_BITS) ? ST_TRL_PULSE : ST_BIT_PULSE;
                    end
                end
            ST_TRL_PULSE:
                if (lvl && in_window(d, u, h))
                    phase = ST_TRL_SPACE;
            ST_TRL_SPACE:
                if (!lvl && (d + h > u * 10))
                begin
                    if (rpt_cnt == 0 || rpt_cnt >= rpt_thresh)
                    begin
                        addr  = mirror_byte(shift_reg[31:24]);
                        raddr = mirror_byte(shift_reg[23:16]);
                        cmd   = mirror_byte(shift_reg[15:8]);
                        rcmd  = mirror_byte(shift_reg[7:0]);
                        if ((cmd ^ rcmd) != 8'hff)
                            res.code = shift_reg;
                        else if ((addr ^ raddr) != 8'hff)
                            res.code = {8'd0, addr, raddr, cmd};
                        else
                            res.code = {16'd0, addr, cmd};
                        res.valid = 1'b1;
                        codes++;
                        if (rpt_cnt != 0)
                            repeat_codes++;
                    end
                    phase = ST_IDLE;
                end
            default:
                phase = ST_IDLE;
        endcase
        want_q.push_back(res);
    endfunction

    function void check_code(logic [NIRP_CODE_W-1:0] code, logic valid);
        ir_result_t want;
        results++;
        if (want_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %0d: code %h valid %b", results, code, valid);
            return;
        end
        want = want_q.pop_front();
        if (code !== want.code || valid !== want.valid)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: code %h valid %b, expected code %h valid %b",
                         results, code, valid, want.code, want.valid);
        end
    endfunction

    function int pending();
        return want_q.size();
    endfunction
endclass

module nec_ir_pulse_decoder_top_tb;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [23:0]            s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [NIRP_CODE_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [NIRP_CFG_W-1:0]  cfg_data;

    ir_code_scoreboard sb;

    // steady: no idling on either side; hold_len: one-shot receiver hold-off
    bit steady;
    int hold_len;

    nec_ir_pulse_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well past the slowest legal run (stalls, holds, long units).
    initial
    begin
        #800000;
        $display("nec_ir_pulse_decoder_top regression: fail");
        $finish;
    end

    // idle with a chance of 18 in a hundred per call unless a steady stretch is on
    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 18);
    endfunction

    // Result side: tready moves on the falling edge. A requested hold-off is
    // counted down here, independent of the sender.
    initial
    begin : rx_side
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= rst_n && !take_gap();
        end
    end

    // every accepted result is checked against the oldest predicted code
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_code(m_tdata, m_tuser);

    // Offers one edge; called at a falling edge, returns at a falling edge.
    // tvalid is only dropped for a gap, so back-to-back edges keep it high.
    task automatic send_edge(input logic lvl, input logic [NIRP_DUR_W-1:0] dur);
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= lvl;
        s_tdata  <= {4'b0000, dur};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_edge(lvl, dur);
        @(negedge clk);
    endtask

    // Register writes only with nothing in flight: every edge owes a result,
    // so once no result is owed the pipe is empty.
    task automatic write_reg(input logic idx, input logic [NIRP_CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random duration inside the open window (c - m, c + m); exact c if it is empty
    function automatic logic [NIRP_DUR_W-1:0] pick_in(int unsigned c, int unsigned m);
        if (m == 0)
            return c[NIRP_DUR_W-1:0];
        return NIRP_DUR_W'($urandom_range(c + m - 1, c - m + 1));
    endfunction

    function automatic logic [NIRP_DUR_W-1:0] trailer_gap();
        int unsigned u;
        u = 32'(sb.unit_time);
        if ($urandom_range(0, 9) == 0)
            return 20'hfffff;
        return NIRP_DUR_W'(10 * u - u / 2 + 1 + $urandom_range(0, 4 * u));
    endfunction

    // junk: full range, near the timing grid, window edges, tiny
    function automatic logic [NIRP_DUR_W-1:0] junk_duration();
        int unsigned u, c;
        u = 32'(sb.unit_time);
        c = u * $urandom_range(1, 18);
        case ($urandom_range(0, 3))
            0:       return NIRP_DUR_W'($urandom_range(0, 20'hfffff));
            1:       return NIRP_DUR_W'($urandom_range(0, 20 * u));
            2:       return NIRP_DUR_W'($urandom_range(0, 1) ? c - u / 2 : c + u / 2);
            default: return NIRP_DUR_W'($urandom_range(0, 15));
        endcase
    endfunction

    // payload as it goes on the air: plain, extended address, failed check, all 0/1
    function automatic logic [31:0] frame_bits();
        logic [7:0] a, b, c;
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0, 1:
                return {a, ~a, c, ~c};
            2:
            begin
                if (b == ~a)
                    b = b ^ 8'h01;
                return {a, b, c, ~c};
            end
            3:
                return {16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 16'hffff))};
            default:
                return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
        endcase
    endfunction

    // Sends one expected edge, sometimes preceded by a stray one: either the
    // wrong level (ignored) or the right level at a junk duration.
    task automatic send_part(input logic lvl, input logic [NIRP_DUR_W-1:0] dur,
                             input int noise);
        if ($urandom_range(0, 99) < noise)
            send_edge($urandom_range(0, 1) ? !lvl : lvl, junk_duration());
        send_edge(lvl, dur);
    endtask

    task automatic send_frame(input logic [31:0] bits, input int noise);
        int unsigned u, h;
        u = 32'(sb.unit_time);
        h = u / 2;
        send_part(1'b1, pick_in(16 * u, 2 * u), noise);
        send_part(1'b0, pick_in(8 * u, u), noise);
        for (int i = 31; i >= 0; i--)
        begin
            send_part(1'b1, pick_in(u, h), noise);
            send_part(1'b0, bits[i] ? pick_in(3 * u, h) : pick_in(u, h), noise);
        end
        send_part(1'b1, pick_in(u, h), noise);
        send_part(1'b0, trailer_gap(), noise);
    endtask

    task automatic send_repeat(input int noise);
        int unsigned u, h;
        u = 32'(sb.unit_time);
        h = u / 2;
        send_part(1'b1, pick_in(16 * u, 2 * u), noise);
        send_part(1'b0, pick_in(4 * u, h), noise);
        send_part(1'b1, pick_in(u, h), noise);
        send_part(1'b0, trailer_gap(), noise);
    endtask

    // mostly clean frames and repeat bursts, with some junk between them
    task automatic run_mix(input int n);
        int stop_at, pick, noise;
        stop_at = sb.edges + n;
        while (sb.edges < stop_at)
        begin
            pick  = $urandom_range(0, 9);
            noise = ($urandom_range(0, 3) == 0) ? 4 : 0;
            if (pick < 5)
                send_frame(frame_bits(), noise);
            else if (pick < 8)
                repeat ($urandom_range(1, 8)) send_repeat(noise);
            else
                repeat ($urandom_range(1, 6)) send_edge(1'($urandom_range(0, 1)), junk_duration());
        end
    endtask

    initial
    begin : main
        int unsigned u, h;
        sb        = new();
        steady    = 1'b0;
        hold_len  = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_UNIT_TIME;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed, reset settings (unit 560, threshold 5) ----
        u = 32'(sb.unit_time);
        h = u / 2;
        // repeat frame with no data frame before it: count 1 is under the threshold
        send_edge(1'b1, NIRP_DUR_W'(16 * u));
        send_edge(1'b0, NIRP_DUR_W'(4 * u));
        send_edge(1'b1, NIRP_DUR_W'(u));
        send_edge(1'b0, NIRP_DUR_W'(10 * u));
        // space where a header pulse belongs, then the duration extremes
        send_edge(1'b0, NIRP_DUR_W'(16 * u));
        send_edge(1'b1, '0);
        send_edge(1'b1, 20'hfffff);
        // header pulse at the lower window edge is rejected, one tick above is taken
        send_edge(1'b1, NIRP_DUR_W'(14 * u));
        send_edge(1'b1, NIRP_DUR_W'(14 * u + 1));
        // pulse in the header space is ignored; a space just past the repeat window
        // sends the walker back to idle
        send_edge(1'b1, NIRP_DUR_W'(8 * u));
        send_edge(1'b0, NIRP_DUR_W'(4 * u + h));
        // header at the top of its window, space at the bottom of the data window
        send_edge(1'b1, NIRP_DUR_W'(18 * u - 1));
        send_edge(1'b0, NIRP_DUR_W'(7 * u + 1));
        // bit pulse: wrong level, lower edge rejected, upper edge taken
        send_edge(1'b0, NIRP_DUR_W'(u));
        send_edge(1'b1, NIRP_DUR_W'(u - h));
        send_edge(1'b1, NIRP_DUR_W'(u + h - 1));
        // space between the 0 and 1 windows: shifts a zero, bit not counted
        send_edge(1'b0, NIRP_DUR_W'(2 * u));
        // a 1 just inside its window
        send_edge(1'b0, NIRP_DUR_W'(3 * u - h + 1));
        // ... the frame gets finished by the stimulus that follows

        // ---- defaults, random; frame of all zeros still flags a code ----
        send_frame(32'h0, 0);
        send_frame(32'h00ff_00ff, 0);
        run_mix(60);

        // ---- smallest unit: bit and repeat windows collapse, so no repeat reaches the threshold of 1 ----
        write_reg(REG_UNIT_TIME, 12'd1);
        write_reg(REG_REPEAT_THR, 12'd1);
        run_mix(50);

        // ---- largest unit and threshold: one data frame, then a run of repeats
        // that all stay under the threshold and emit nothing ----
        write_reg(REG_UNIT_TIME, 12'd4095);
        write_reg(REG_REPEAT_THR, 12'd255);
        send_frame(frame_bits(), 0);
        repeat (16) send_repeat(0);

        // ---- small unit, no idling anywhere, and a long receiver hold-off while
        // edges keep coming, so the queue fills and s_tready drops ----
        write_reg(REG_UNIT_TIME, 12'd37);
        write_reg(REG_REPEAT_THR, 12'd2);
        steady   = 1'b1;
        hold_len = 150;
        run_mix(90);
        steady   = 1'b0;

        // ---- random settings ----
        write_reg(REG_UNIT_TIME, NIRP_CFG_W'($urandom_range(1, 4095)));
        write_reg(REG_REPEAT_THR, NIRP_CFG_W'($urandom_range(1, 255)));
        run_mix(50);

        write_reg(REG_UNIT_TIME, 12'd560);
        write_reg(REG_REPEAT_THR, 12'd3);
        run_mix(50);

        // drain; the timeout block catches anything that never arrives
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("run summary: %0d edges over %0d register writes, %0d results checked",
                 sb.edges, sb.reg_writes, sb.results);
        $display("run summary: %0d codes flagged (%0d from repeat frames), %0d mismatches",
                 sb.codes, sb.repeat_codes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("nec_ir_pulse_decoder_top regression: pass");
        else
            $display("nec_ir_pulse_decoder_top regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/nirp_pkg.sv
hdl/nirp_front.sv
hdl/nirp_fifo.sv
hdl/nirp_back.sv
hdl/nec_ir_pulse_decoder_top.sv
test/nec_ir_pulse_decoder_top_tb.sv
